[rtl/pfc_pkg.sv]
package pfc_pkg;

   // Field widths.
   localparam int PIX_W     = 17;
   localparam int MODE_W    = 3;
   localparam int RANGE_W   = 16;
   localparam int CNT_W     = 25;
   localparam int QUOT_BITS = 8;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int IDX_W     = 2;

   localparam int unsigned MAX_IMAGE_PIXELS_DEF = 16777216;

   // Conversion modes.
   localparam logic [MODE_W-1:0] MODE_PASS      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_U2S_TRUNC = 3'd1;
   localparam logic [MODE_W-1:0] MODE_U2S_HALVE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_U2S_SHIFT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_S2U_TRUNC = 3'd4;
   localparam logic [MODE_W-1:0] MODE_S2U_SHIFT = 3'd5;
   localparam logic [MODE_W-1:0] MODE_WIDEN     = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SCALE     = 3'd7;

   // Register indexes (byte address = 4 * index).
   localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
   localparam logic [IDX_W-1:0] REG_LOW   = 2'd1;
   localparam logic [IDX_W-1:0] REG_RANGE = 2'd2;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 16'd256;
   localparam logic [PIX_W-1:0]   S16_MAX     = 17'd32767;
   localparam logic [PIX_W-1:0]   BYTE_MAX    = 17'd255;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PIX_W-1:0]   scale_low;
      logic [RANGE_W-1:0] scale_range;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scale_mode;
      logic out_busy;
   } sts_type;

endpackage

[rtl/pixel_format_converter_top.sv]
// Pixel format converter. Each transfer on the req_ channel carries one pixel and an
// end-of-image marker; exactly one transfer on the rsp_ channel carries the converted
// pixel, a flag telling whether this pixel was clamped, the running clamp count for the
// current image and the echoed marker. The mode register selects pass-through, three
// unsigned-to-signed conversions, two signed-to-unsigned conversions, byte widening or
// scaling to a byte. The block works on one pixel at a time: it takes no new input
// transfer until the current pixel has gone into the output register, and a scaling
// pixel first passes through the restoring divider for its scale quotient, which
// produces one of its 8 quotient bits per cycle. The result sits in an output register,
// so the next pixel is taken while a stalled result still waits downstream. Registers
// sit on the APB port at byte addresses 0 (mode), 4 (scale low) and 8 (scale range) and
// are meant to be written only while no pixel is in flight.
module pixel_format_converter_top #(
   parameter int unsigned MAX_IMAGE_PIXELS = pfc_pkg::MAX_IMAGE_PIXELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   // Input pixel channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pfc_pkg::PIX_W-1:0]     req_pixel_in,
   input  logic                          req_last_pixel,

   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pfc_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                          rsp_was_truncated,
   output logic [pfc_pkg::CNT_W-1:0]     rsp_truncated_total,
   output logic                          rsp_image_done,

   // Register port.
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pfc_pkg::ADDR_W-1:0]    paddr,
   input  logic [pfc_pkg::DATA_W-1:0]    pwdata,
   output logic [pfc_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   pfc_pkg::cfg_type cfg;
   pfc_pkg::cmd_type cmd;
   pfc_pkg::sts_type sts;

   // The register file holds mode and scale settings; the datapath reads them directly, so
   // they are to be changed only between pixels, which the block itself does not enforce.
   pfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The controller sequences load, divide steps and the hand-off into the output
   // register, and holds off new input transfers while a pixel is in flight.
   pfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the captured pixel, the divider, the per-image clamp counter and
   // the output register.
   pfc_dp #(
      .MAX_IMAGE_PIXELS (MAX_IMAGE_PIXELS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_pixel_in        (req_pixel_in),
      .req_last_pixel      (req_last_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pixel_out       (rsp_pixel_out),
      .rsp_was_truncated   (rsp_was_truncated),
      .rsp_truncated_total (rsp_truncated_total),
      .rsp_image_done      (rsp_image_done)
   );

endmodule

[rtl/pfc_csr.sv]
module pfc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pfc_pkg::ADDR_W-1:0]   paddr,
   input  logic [pfc_pkg::DATA_W-1:0]   pwdata,
   output logic [pfc_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output pfc_pkg::cfg_type             cfg
);

   pfc_pkg::cfg_type cfg_ff, cfg_in;
   logic [pfc_pkg::IDX_W-1:0] idx;
   logic wr_en;

   assign pready = 1'b1;
   assign idx    = paddr[pfc_pkg::ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            pfc_pkg::REG_MODE:  cfg_in.mode        = pwdata[pfc_pkg::MODE_W-1:0];
            pfc_pkg::REG_LOW:   cfg_in.scale_low   = pwdata[pfc_pkg::PIX_W-1:0];
            pfc_pkg::REG_RANGE: cfg_in.scale_range = pwdata[pfc_pkg::RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         pfc_pkg::REG_MODE:
            prdata = {{(pfc_pkg::DATA_W-pfc_pkg::MODE_W){1'b0}}, cfg_ff.mode};
         pfc_pkg::REG_LOW:
            prdata = {{(pfc_pkg::DATA_W-pfc_pkg::PIX_W){cfg_ff.scale_low[pfc_pkg::PIX_W-1]}},
                      cfg_ff.scale_low};
         pfc_pkg::REG_RANGE:
            prdata = {{(pfc_pkg::DATA_W-pfc_pkg::RANGE_W){1'b0}}, cfg_ff.scale_range};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= pfc_pkg::MODE_PASS;
         cfg_ff.scale_low   <= '0;
         cfg_ff.scale_range <= pfc_pkg::RANGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/pfc_ctrl.sv]
module pfc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pfc_pkg::sts_type   sts,
   output pfc_pkg::cmd_type   cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int STEP_W = $clog2(pfc_pkg::QUOT_BITS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(pfc_pkg::QUOT_BITS - 1);

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.finish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = sts.scale_mode ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[rtl/pfc_dp.sv]
module pfc_dp #(
   parameter int unsigned MAX_IMAGE_PIXELS = pfc_pkg::MAX_IMAGE_PIXELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pfc_pkg::cfg_type              cfg,
   input  pfc_pkg::cmd_type              cmd,
   output pfc_pkg::sts_type              sts,
   input  logic [pfc_pkg::PIX_W-1:0]     req_pixel_in,
   input  logic                          req_last_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pfc_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                          rsp_was_truncated,
   output logic [pfc_pkg::CNT_W-1:0]     rsp_truncated_total,
   output logic                          rsp_image_done
);

   localparam int PW = pfc_pkg::PIX_W;
   localparam int RW = pfc_pkg::RANGE_W;
   localparam int CW = pfc_pkg::CNT_W;
   localparam int QW = pfc_pkg::QUOT_BITS;
   localparam logic [CW-1:0] CNT_MAX = MAX_IMAGE_PIXELS[CW-1:0];

   // Captured item and divider state.
   logic [PW-1:0] pix_ff, pix_in;
   logic          last_ff, last_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic          nonpos_ff, nonpos_in;
   logic          sat_ff, sat_in;

   // Output register and running count.
   logic          vld_ff, vld_in;
   logic [PW-1:0] out_pix_ff, out_pix_in;
   logic          out_trunc_ff, out_trunc_in;
   logic [CW-1:0] out_total_ff, out_total_in;
   logic          out_done_ff, out_done_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [RW-1:0] range_eff;
   logic [PW:0]   diff;
   logic          diff_pos;
   logic [RW:0]   dbl;
   logic [RW:0]   dbl_sub;
   logic          ge;
   logic [PW-1:0] conv_pix;
   logic          conv_trunc;
   logic [CW-1:0] total;

   assign range_eff = (cfg.scale_range == '0) ? RW'(1) : cfg.scale_range;

   // Offset from the scale floor, one bit wider than the operands.
   assign diff     = {req_pixel_in[PW-1], req_pixel_in} - {cfg.scale_low[PW-1], cfg.scale_low};
   assign diff_pos = !diff[PW] && (diff != '0);

   // One restoring step per cycle: for a pixel inside the window the remainder stays below the range.
   assign dbl     = {rem_ff, 1'b0};
   assign dbl_sub = dbl - {1'b0, range_eff};
   assign ge      = (dbl >= {1'b0, range_eff});

   always_comb begin
      pix_in    = pix_ff;
      last_in   = last_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      nonpos_in = nonpos_ff;
      sat_in    = sat_ff;
      if (cmd.load) begin
         pix_in    = req_pixel_in;
         last_in   = req_last_pixel;
         rem_in    = diff[RW-1:0];
         quot_in   = '0;
         nonpos_in = !diff_pos;
         sat_in    = diff_pos && (diff[PW-1:0] >= {1'b0, range_eff});
      end else if (cmd.div_step) begin
         rem_in  = ge ? dbl_sub[RW-1:0] : dbl[RW-1:0];
         quot_in = {quot_ff[QW-2:0], ge};
      end
   end

   always_comb begin
      conv_trunc = 1'b0;
      case (cfg.mode)
         pfc_pkg::MODE_PASS: begin
            conv_pix = pix_ff;
         end
         pfc_pkg::MODE_U2S_TRUNC: begin
            if (pix_ff[15]) begin
               conv_pix   = pfc_pkg::S16_MAX;
               conv_trunc = 1'b1;
            end else begin
               conv_pix = {1'b0, pix_ff[15:0]};
            end
         end
         pfc_pkg::MODE_U2S_HALVE: begin
            conv_pix = {2'b00, pix_ff[15:1]};
         end
         pfc_pkg::MODE_U2S_SHIFT: begin
            conv_pix = {~pix_ff[15], ~pix_ff[15], pix_ff[14:0]};
         end
         pfc_pkg::MODE_S2U_TRUNC: begin
            if (pix_ff[15]) begin
               conv_pix   = '0;
               conv_trunc = 1'b1;
            end else begin
               conv_pix = {1'b0, pix_ff[15:0]};
            end
         end
         pfc_pkg::MODE_S2U_SHIFT: begin
            conv_pix = {1'b0, ~pix_ff[15], pix_ff[14:0]};
         end
         pfc_pkg::MODE_WIDEN: begin
            conv_pix = {{(PW-8){1'b0}}, pix_ff[7:0]};
         end
         pfc_pkg::MODE_SCALE: begin
            if (nonpos_ff) begin
               conv_pix = '0;
            end else if (sat_ff) begin
               conv_pix = pfc_pkg::BYTE_MAX;
            end else begin
               conv_pix = {{(PW-QW){1'b0}}, quot_ff};
            end
         end
         default: begin
            conv_pix = '0;
         end
      endcase
   end

   assign total = (conv_trunc && (cnt_ff < CNT_MAX)) ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      vld_in       = vld_ff & rsp_stall;
      out_pix_in   = out_pix_ff;
      out_trunc_in = out_trunc_ff;
      out_total_in = out_total_ff;
      out_done_in  = out_done_ff;
      cnt_in       = cnt_ff;
      if (cmd.finish) begin
         vld_in       = 1'b1;
         out_pix_in   = conv_pix;
         out_trunc_in = conv_trunc;
         out_total_in = total;
         out_done_in  = last_ff;
         cnt_in       = last_ff ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      last_ff      <= last_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      nonpos_ff    <= nonpos_in;
      sat_ff       <= sat_in;
      out_pix_ff   <= out_pix_in;
      out_trunc_ff <= out_trunc_in;
      out_total_ff <= out_total_in;
      out_done_ff  <= out_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
   end

   assign sts.scale_mode = (cfg.mode == pfc_pkg::MODE_SCALE);
   assign sts.out_busy   = vld_ff & rsp_stall;

   assign rsp_valid           = vld_ff;
   assign rsp_pixel_out       = out_pix_ff;
   assign rsp_was_truncated   = out_trunc_ff;
   assign rsp_truncated_total = out_total_ff;
   assign rsp_image_done      = out_done_ff;

endmodule

[rtl/pfc_checker.sv]
module pfc_checker #(
   parameter int unsigned MAX_IMAGE_PIXELS = pfc_pkg::MAX_IMAGE_PIXELS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [pfc_pkg::PIX_W-1:0]     rsp_pixel_out,
   input logic                          rsp_was_truncated,
   input logic [pfc_pkg::CNT_W-1:0]     rsp_truncated_total,
   input logic                          rsp_image_done
);

   // A stalled result stays offered, with its pixel, total and end marker unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
         && $stable(rsp_truncated_total) && $stable(rsp_image_done))
      else $error("stalled result changed");

   // A clamped pixel is counted, so the running total cannot be zero.
   a_trunc_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_truncated |-> rsp_truncated_total != '0)
      else $error("clamped pixel not counted");

   // Clamping only ever produces the signed maximum or zero.
   a_trunc_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_truncated |-> rsp_pixel_out == pfc_pkg::S16_MAX
         || rsp_pixel_out == '0)
      else $error("clamped pixel has unexpected value");

   // The per-image count saturates at the configured limit.
   a_total_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_truncated_total <= MAX_IMAGE_PIXELS)
      else $error("clamp count above limit");

   // No result leaves the block right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind pixel_format_converter_top pfc_checker #(
   .MAX_IMAGE_PIXELS (MAX_IMAGE_PIXELS)
) u_pfc_checker (.*);

[tb/tb_pixel_format_converter_top.sv]
`timescale 1ns / 100ps

module tb_pixel_format_converter_top;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 10;
   localparam int PHASE_COUNT  = 24;
   localparam int PHASE_PIXELS = 64;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 30;
   localparam int CYCLE_LIMIT  = 500000;

   // One converted pixel as it should appear on the result channel.
   typedef struct packed {
      logic [pfc_pkg::PIX_W-1:0] pixel;
      logic                      clamped;
      logic [pfc_pkg::CNT_W-1:0] clamp_total;
      logic                      image_end;
   } converted_pixel_type;

   // The scoreboard converts each accepted pixel with its own copy of the registers
   // and queues the result until the matching rsp_ transfer shows up.
   class conversion_scoreboard_type;
      pfc_pkg::cfg_type          cfg;
      logic [pfc_pkg::CNT_W-1:0] clamp_count;
      converted_pixel_type       awaited[$];
      int                        errors;

      function new();
         cfg.mode        = pfc_pkg::MODE_PASS;
         cfg.scale_low   = '0;
         cfg.scale_range = pfc_pkg::RANGE_RESET;
         clamp_count     = '0;
         errors          = 0;
      endfunction

      function void write_reg(logic [pfc_pkg::IDX_W-1:0] idx,
                              logic [pfc_pkg::DATA_W-1:0] value);
         case (idx)
            pfc_pkg::REG_MODE:  cfg.mode = value[pfc_pkg::MODE_W-1:0];
            pfc_pkg::REG_LOW:   cfg.scale_low = value[pfc_pkg::PIX_W-1:0];
            pfc_pkg::REG_RANGE: cfg.scale_range = value[pfc_pkg::RANGE_W-1:0];
            default: ;
         endcase
      endfunction

      function void check_register(logic [pfc_pkg::IDX_W-1:0] idx,
                                   logic [pfc_pkg::DATA_W-1:0] data);
         case (idx)
            pfc_pkg::REG_MODE:
               if (data[pfc_pkg::MODE_W-1:0] !== cfg.mode) begin
                  $error("conversion_mode readback: expected %0d, got %0d", cfg.mode,
                         data[pfc_pkg::MODE_W-1:0]);
                  errors++;
               end
            pfc_pkg::REG_LOW:
               if (data[pfc_pkg::PIX_W-1:0] !== cfg.scale_low) begin
                  $error("scale_low readback: expected %0d, got %0d",
                         $signed(cfg.scale_low), $signed(data[pfc_pkg::PIX_W-1:0]));
                  errors++;
               end
            pfc_pkg::REG_RANGE:
               if (data[pfc_pkg::RANGE_W-1:0] !== cfg.scale_range) begin
                  $error("scale_range readback: expected %0d, got %0d", cfg.scale_range,
                         data[pfc_pkg::RANGE_W-1:0]);
                  errors++;
               end
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [pfc_pkg::PIX_W-1:0] px, logic last);
         converted_pixel_type conv;
         logic [15:0]         sample;
         int                  value;
         int                  span;
         sample       = px[15:0];
         conv.clamped = 1'b0;
         value        = 0;
         case (cfg.mode)
            pfc_pkg::MODE_PASS: value = int'($signed(px));
            pfc_pkg::MODE_U2S_TRUNC:
               if (sample[15]) begin
                  value        = 32767;
                  conv.clamped = 1'b1;
               end else begin
                  value = int'(sample);
               end
            pfc_pkg::MODE_U2S_HALVE: value = int'(sample) >> 1;
            pfc_pkg::MODE_U2S_SHIFT: value = int'(sample) - 32768;
            pfc_pkg::MODE_S2U_TRUNC:
               if (sample[15]) begin
                  value        = 0;
                  conv.clamped = 1'b1;
               end else begin
                  value = int'(sample);
               end
            pfc_pkg::MODE_S2U_SHIFT: value = int'($signed(sample)) + 32768;
            pfc_pkg::MODE_WIDEN:     value = int'(px[7:0]);
            pfc_pkg::MODE_SCALE: begin
               span  = (cfg.scale_range == '0) ? 1 : int'(cfg.scale_range);
               value = ((int'($signed(px)) - int'($signed(cfg.scale_low))) * 256) / span;
               if (value < 0) begin
                  value = 0;
               end else if (value > 255) begin
                  value = 255;
               end
            end
            default: value = 0;
         endcase
         if (conv.clamped &&
             clamp_count < pfc_pkg::CNT_W'(pfc_pkg::MAX_IMAGE_PIXELS_DEF)) begin
            clamp_count++;
         end
         conv.pixel       = value[pfc_pkg::PIX_W-1:0];
         conv.clamp_total = clamp_count;
         conv.image_end   = last;
         if (last) begin
            clamp_count = '0;
         end
         awaited.push_back(conv);
      endfunction

      function void check_result(logic [pfc_pkg::PIX_W-1:0] px, logic clamped,
                                 logic [pfc_pkg::CNT_W-1:0] total, logic done);
         converted_pixel_type conv;
         if (awaited.size() == 0) begin
            $error("result transfer with no pixel outstanding: pixel_out %0d", $signed(px));
            errors++;
            return;
         end
         conv = awaited.pop_front();
         if (px !== conv.pixel) begin
            $error("pixel_out: expected %0d, got %0d", $signed(conv.pixel), $signed(px));
            errors++;
         end
         if (clamped !== conv.clamped) begin
            $error("was_truncated: expected %0d, got %0d", conv.clamped, clamped);
            errors++;
         end
         if (total !== conv.clamp_total) begin
            $error("truncated_total: expected %0d, got %0d", conv.clamp_total, total);
            errors++;
         end
         if (done !== conv.image_end) begin
            $error("image_done: expected %0d, got %0d", conv.image_end, done);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   // Every input of the block starts at a known value. Reset is held from time zero.
   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic [pfc_pkg::PIX_W-1:0]  req_pixel_in   = '0;
   logic                       req_last_pixel = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b1;
   logic [pfc_pkg::PIX_W-1:0]  rsp_pixel_out;
   logic                       rsp_was_truncated;
   logic [pfc_pkg::CNT_W-1:0]  rsp_truncated_total;
   logic                       rsp_image_done;
   logic                       psel           = 1'b0;
   logic                       penable        = 1'b0;
   logic                       pwrite         = 1'b0;
   logic [pfc_pkg::ADDR_W-1:0] paddr          = '0;
   logic [pfc_pkg::DATA_W-1:0] pwdata         = '0;
   logic [pfc_pkg::DATA_W-1:0] prdata;
   logic                       pready;

   // Idle percentages for the two sides, changed by the stimulus as the run moves on.
   int tx_idle_pct  = 12;
   int rx_idle_pct  = 83;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   bit hold_request = 1'b0;
   int cycle_count  = 0;

   conversion_scoreboard_type board = new();

   pixel_format_converter_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel_in        (req_pixel_in),
      .req_last_pixel      (req_last_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pixel_out       (rsp_pixel_out),
      .rsp_was_truncated   (rsp_was_truncated),
      .rsp_truncated_total (rsp_truncated_total),
      .rsp_image_done      (rsp_image_done),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      forever begin
         #(CLOCK_PERIOD / 2) clock = ~clock;
      end
   end

   // The run is bounded: if the block hangs, the bench gives up with the failure line.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result monitor. Outputs are read right after the rising edge, before any
   // nonblocking update of that step lands, so they hold the values seen at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_pixel_out, rsp_was_truncated, rsp_truncated_total,
                            rsp_image_done);
      end
   end

   // Receiver. Normally it stalls at random; on request it holds off for a long,
   // counted stretch so that the output register fills and the block stalls its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
         end
      end
   end

   // Offers one pixel, possibly after some idle cycles, and returns at the edge where
   // the transfer happens. Valid stays high afterward so back-to-back pixels do not
   // drop it for a cycle; the caller lowers it when the stream pauses.
   task automatic send_pixel(input logic [pfc_pkg::PIX_W-1:0] px, input logic last);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_in   <= px;
      req_last_pixel <= last;
      do @(posedge clock); while (req_stall);
      board.note_pixel(px, last);
   endtask

   // Register write followed by a readback of the same register. pready is always
   // high, but the access phase still waits for it as the protocol says. The port
   // returns to idle before the task ends.
   task automatic csr_write(input logic [pfc_pkg::IDX_W-1:0] idx,
                            input logic [pfc_pkg::DATA_W-1:0] value);
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      pwrite  <= 1'b1;
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.write_reg(idx, value);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.check_register(idx, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // The block is only reconfigured with nothing in flight. Since every pixel gives
   // exactly one result, an empty scoreboard means the block is idle.
   task automatic apply_setting(input logic [pfc_pkg::MODE_W-1:0] mode, input int low,
                                input int span);
      req_valid <= 1'b0;
      wait_drained();
      csr_write(pfc_pkg::REG_MODE, pfc_pkg::DATA_W'(mode));
      csr_write(pfc_pkg::REG_LOW, pfc_pkg::DATA_W'(low));
      csr_write(pfc_pkg::REG_RANGE, pfc_pkg::DATA_W'(span));
   endtask

   // A directed pixel under a given setting; registers are rewritten only on a change.
   task automatic directed_pixel(input logic [pfc_pkg::MODE_W-1:0] mode, input int low,
                                 input int span, input int px, input logic last);
      if (board.cfg.mode != mode || board.cfg.scale_low != pfc_pkg::PIX_W'(low) ||
          board.cfg.scale_range != pfc_pkg::RANGE_W'(span)) begin
         apply_setting(mode, low, span);
      end
      send_pixel(pfc_pkg::PIX_W'(px), last);
   endtask

   // Random pixel over the field's range. Three in eight are corner values. In scale mode
   // half land around the configured window so that the quotient spreads over the
   // whole byte rather than sitting on the clamps.
   function automatic logic [pfc_pkg::PIX_W-1:0] random_pixel(
      input logic [pfc_pkg::MODE_W-1:0] mode, input int low, input int span);
      int px;
      case ($urandom_range(0, 7))
         0: px = -32768;
         1: px = 65535;
         2: begin
            case ($urandom_range(0, 5))
               0: px = -1;
               1: px = 0;
               2: px = 32767;
               3: px = 32768;
               4: px = 255;
               default: px = 256;
            endcase
         end
         default: px = int'($urandom_range(0, 98303)) - 32768;
      endcase
      if (mode == pfc_pkg::MODE_SCALE && $urandom_range(0, 1) == 1) begin
         px = low + int'($urandom_range(0, span + span / 4)) - span / 8;
         if (px < -32768) begin
            px = -32768;
         end else if (px > 65535) begin
            px = 65535;
         end
      end
      return pfc_pkg::PIX_W'(px);
   endfunction

   initial begin
      logic [pfc_pkg::MODE_W-1:0] mode;
      int                         low;
      int                         span;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, under the first idling pattern. Pass-through at the extremes of
      // the pixel field, run on the reset values of the registers.
      directed_pixel(pfc_pkg::MODE_PASS, 0, 256, -32768, 1'b0);
      directed_pixel(pfc_pkg::MODE_PASS, 0, 256, 65535, 1'b0);
      directed_pixel(pfc_pkg::MODE_PASS, 0, 256, 0, 1'b1);
      // Unsigned-to-signed clamp: the first value above the signed maximum clamps, and
      // a negative pixel clamps too since only its low 16 bits count. The running
      // total climbs through the image and shows on the last pixel before clearing.
      directed_pixel(pfc_pkg::MODE_U2S_TRUNC, 0, 256, 32767, 1'b0);
      directed_pixel(pfc_pkg::MODE_U2S_TRUNC, 0, 256, 32768, 1'b0);
      directed_pixel(pfc_pkg::MODE_U2S_TRUNC, 0, 256, 65535, 1'b0);
      directed_pixel(pfc_pkg::MODE_U2S_TRUNC, 0, 256, -1, 1'b1);
      directed_pixel(pfc_pkg::MODE_U2S_HALVE, 0, 256, 65535, 1'b0);
      directed_pixel(pfc_pkg::MODE_U2S_HALVE, 0, 256, -32767, 1'b0);
      directed_pixel(pfc_pkg::MODE_U2S_SHIFT, 0, 256, 0, 1'b0);
      directed_pixel(pfc_pkg::MODE_U2S_SHIFT, 0, 256, 65535, 1'b1);
      // Signed-to-unsigned clamp: negatives clamp to zero, and bit 16 is ignored, so
      // 65535 reads as -1 here.
      directed_pixel(pfc_pkg::MODE_S2U_TRUNC, 0, 256, -32768, 1'b0);
      directed_pixel(pfc_pkg::MODE_S2U_TRUNC, 0, 256, 32767, 1'b0);
      directed_pixel(pfc_pkg::MODE_S2U_TRUNC, 0, 256, 65535, 1'b1);
      // The clamp count starts over in the next image; non-clamping modes report it.
      directed_pixel(pfc_pkg::MODE_S2U_SHIFT, 0, 256, -32768, 1'b0);
      directed_pixel(pfc_pkg::MODE_S2U_SHIFT, 0, 256, 32767, 1'b0);
      directed_pixel(pfc_pkg::MODE_WIDEN, 0, 256, 255, 1'b0);
      directed_pixel(pfc_pkg::MODE_WIDEN, 0, 256, 256, 1'b0);
      directed_pixel(pfc_pkg::MODE_WIDEN, 0, 256, -1, 1'b1);
      // Scale mode: widest window, then the highest low with a zero range, which the
      // block takes as a range of one, then the narrowest nonzero window.
      directed_pixel(pfc_pkg::MODE_SCALE, -32768, 65535, 65535, 1'b0);
      directed_pixel(pfc_pkg::MODE_SCALE, -32768, 65535, -32768, 1'b0);
      directed_pixel(pfc_pkg::MODE_SCALE, -32768, 65535, 0, 1'b0);
      directed_pixel(pfc_pkg::MODE_SCALE, 65535, 0, 0, 1'b0);
      directed_pixel(pfc_pkg::MODE_SCALE, 65535, 0, 65535, 1'b0);
      directed_pixel(pfc_pkg::MODE_SCALE, 0, 1, 1, 1'b1);

      // Random part. Each phase programs a fresh setting and streams images of random
      // length. The modes rotate so every pattern of idling meets every mode.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == PHASE_COUNT / 3) begin
            tx_idle_pct = 83;
            rx_idle_pct = 12;
         end else if (phase == 2 * PHASE_COUNT / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         mode = pfc_pkg::MODE_W'(phase % 8);
         case ($urandom_range(0, 3))
            0: low = -32768;
            1: low = 65535;
            default: low = int'($urandom_range(0, 98303)) - 32768;
         endcase
         case ($urandom_range(0, 3))
            0: span = 1;
            1: span = 65535;
            default: span = int'($urandom_range(1, 2000));
         endcase
         apply_setting(mode, low, span);
         // With the sender running flat out, a long hold-off on the result side
         // backs the block up and forces it to stall its input.
         if (phase == 2 * PHASE_COUNT / 3 + 2) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            send_pixel(random_pixel(mode, low, span), $urandom_range(0, 15) == 0);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
rtl/pfc_pkg.sv
rtl/pfc_csr.sv
rtl/pfc_ctrl.sv
rtl/pfc_dp.sv
rtl/pixel_format_converter_top.sv
rtl/pfc_checker.sv
tb/tb_pixel_format_converter_top.sv
